// File: rtl/core/sst_pkg.sv
// shared types and constants for the step sequencer trigger
`default_nettype none

package sst_pkg;

    localparam int FRAME_W   = 24;
    localparam int ACTION_W  = 3;
    localparam int NSTEPS_W  = 5;
    localparam int TIDX_W    = 4;
    localparam int PATTERN_W = 16;
    localparam int STEPIDX_W = 4;
    localparam int MASK_W    = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 3'd0,
        ACT_START     = 3'd1,
        ACT_STOP      = 3'd2,
        ACT_SET_LEN   = 3'd3,
        ACT_SET_COUNT = 3'd4,
        ACT_WR_TRACK  = 3'd5
    } action_t;

endpackage

`default_nettype wire

// File: rtl/core/step_sequencer_trigger.sv
// step sequencer trigger: frame/step counters, track patterns and trigger output
`default_nettype none

// Step sequencer trigger. Each input transfer carries one action: a frame
// tick, start, stop, a new step length (in frames), a new step count, or a
// pattern write for one track. While running, every tick counts one frame;
// when the frame count reaches the step length the step counter advances,
// wraps at the active step count and arms a trigger. The next running tick
// with the trigger armed produces one output transfer carrying the current
// step and the mask of tracks whose pattern bit is set at that step (only
// the first four tracks appear in the mask). Changing the step count clears
// every pattern. Rate: one action per cycle while input ready is high;
// each action is finished by one pass of logic (a 24-bit increment, compare
// and subtract on the frame counter) into the state and output registers;
// a tick's result goes to the output register, or to the skid register if
// the output register still holds one. A two-entry output stage (output
// register plus skid register) lets input transfers continue while a result
// waits; input ready drops only when both entries hold results.
module step_sequencer_trigger
    import sst_pkg::*;
#(
    parameter int TRACKS    = 4,
    parameter int MAX_STEPS = 16
)
(
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,

    input  wire  logic                  in_valid,
    output logic                        in_ready,
    input  wire  logic [ACTION_W-1:0]   action,
    input  wire  logic [FRAME_W-1:0]    step_length,
    input  wire  logic [NSTEPS_W-1:0]   num_steps,
    input  wire  logic [TIDX_W-1:0]     track_index,
    input  wire  logic [PATTERN_W-1:0]  pattern_bits,

    output logic                        out_valid,
    input  wire  logic                  out_ready,
    output logic [STEPIDX_W-1:0]        step_index,
    output logic [MASK_W-1:0]           track_mask
);

    // the active step count must hold the reset count of sixteen even for small
    // MAX_STEPS, so size the step registers for whichever is larger
    localparam int STEP_CAP    = (MAX_STEPS > 16) ? MAX_STEPS : 16;
    localparam int STEP_W      = $clog2(STEP_CAP);
    localparam int ACTIVE_W    = $clog2(STEP_CAP + 1);
    localparam int MASK_TRACKS = (TRACKS < MASK_W) ? TRACKS : MASK_W;

    // sequencer state
    logic                 running_reg,   running_next;
    logic                 pending_reg,   pending_next;
    logic [FRAME_W-1:0]   frame_reg,     frame_next;
    logic [FRAME_W-1:0]   fps_reg,       fps_next;
    logic [STEP_W-1:0]    step_reg,      step_next;
    logic [ACTIVE_W-1:0]  active_reg,    active_next;
    logic [PATTERN_W-1:0] pattern_reg  [TRACKS];
    logic [PATTERN_W-1:0] pattern_next [TRACKS];

    // output stage: main register and skid register
    logic                 out_valid_reg,  out_valid_next;
    logic [STEPIDX_W-1:0] out_step_reg,   out_step_next;
    logic [MASK_W-1:0]    out_mask_reg,   out_mask_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [STEPIDX_W-1:0] skid_step_reg,  skid_step_next;
    logic [MASK_W-1:0]    skid_mask_reg,  skid_mask_next;

    logic                 accept;
    logic                 emit;
    logic [STEPIDX_W-1:0] emit_step;
    logic [MASK_W-1:0]    emit_mask;
    logic [FRAME_W-1:0]   frame_inc;
    logic [STEP_W:0]      step_plus;
    logic [ACTIVE_W-1:0]  nsteps_sat;
    logic                 pop;

    assign in_ready   = !skid_valid_reg;
    assign accept     = in_valid && in_ready;
    assign pop        = out_valid_reg && out_ready;

    assign out_valid  = out_valid_reg;
    assign step_index = out_step_reg;
    assign track_mask = out_mask_reg;

    // frame and step arithmetic for a tick
    assign frame_inc  = frame_reg + FRAME_W'(1);
    assign step_plus  = {1'b0, step_reg} + (STEP_W + 1)'(1);
    assign nsteps_sat = (int'(num_steps) > MAX_STEPS) ? ACTIVE_W'(MAX_STEPS)
                                                      : ACTIVE_W'(num_steps);

    // result of a tick: current step and the sounding tracks
    assign emit_step = step_reg[STEPIDX_W-1:0];

    always_comb
    begin
        emit_mask = '0;
        if (int'(step_reg) < PATTERN_W)
        begin
            for (int t = 0; t < MASK_TRACKS; t++)
            begin
                emit_mask[t] = pattern_reg[t][step_reg[STEPIDX_W-1:0]];
            end
        end
    end

    // next state for the accepted action
    always_comb
    begin
        running_next = running_reg;
        pending_next = pending_reg;
        frame_next   = frame_reg;
        fps_next     = fps_reg;
        step_next    = step_reg;
        active_next  = active_reg;
        pattern_next = pattern_reg;
        emit         = 1'b0;

        if (accept)
        begin
            case (action)
                ACT_TICK:
                begin
                    if (running_reg)
                    begin
                        emit = pending_reg &&
                               ({1'b0, step_reg} < (STEP_W + 1)'(active_reg));
                        pending_next = 1'b0;
                        frame_next   = frame_inc;
                        if (frame_inc >= fps_reg)
                        begin
                            frame_next   = frame_inc - fps_reg;
                            pending_next = 1'b1;
                            if (step_plus >= (STEP_W + 1)'(active_reg))
                                step_next = '0;
                            else
                                step_next = step_plus[STEP_W-1:0];
                        end
                    end
                end
                ACT_START:
                begin
                    if (!running_reg)
                    begin
                        step_next    = '0;
                        frame_next   = '0;
                        fps_next     = step_length;
                        pending_next = 1'b1;
                        running_next = 1'b1;
                    end
                end
                ACT_STOP:
                begin
                    running_next = 1'b0;
                end
                ACT_SET_LEN:
                begin
                    fps_next = step_length;
                end
                ACT_SET_COUNT:
                begin
                    // a changed count wipes every pattern
                    if (nsteps_sat != active_reg)
                    begin
                        active_next = nsteps_sat;
                        for (int t = 0; t < TRACKS; t++)
                        begin
                            pattern_next[t] = '0;
                        end
                    end
                end
                ACT_WR_TRACK:
                begin
                    for (int t = 0; t < TRACKS; t++)
                    begin
                        if (int'(track_index) == t)
                            pattern_next[t] = pattern_bits;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output stage: refill from skid on pop, else park a new result
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_step_next   = out_step_reg;
        out_mask_next   = out_mask_reg;
        skid_valid_next = skid_valid_reg;
        skid_step_next  = skid_step_reg;
        skid_mask_next  = skid_mask_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_step_next   = skid_step_reg;
                out_mask_next   = skid_mask_reg;
                skid_valid_next = 1'b0;
            end
        end
        else
        begin
            if (pop)
                out_valid_next = 1'b0;
            if (emit)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_step_next  = emit_step;
                    out_mask_next  = emit_mask;
                end
                else
                begin
                    skid_valid_next = 1'b1;
                    skid_step_next  = emit_step;
                    skid_mask_next  = emit_mask;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            frame_reg      <= '0;
            fps_reg        <= '0;
            step_reg       <= '0;
            active_reg     <= ACTIVE_W'(16);
            for (int t = 0; t < TRACKS; t++)
            begin
                pattern_reg[t] <= '0;
            end
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg    <= running_next;
            pending_reg    <= pending_next;
            frame_reg      <= frame_next;
            fps_reg        <= fps_next;
            step_reg       <= step_next;
            active_reg     <= active_next;
            pattern_reg    <= pattern_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_step_reg  <= out_step_next;
        out_mask_reg  <= out_mask_next;
        skid_step_reg <= skid_step_next;
        skid_mask_reg <= skid_mask_next;
    end

endmodule

`default_nettype wire
